@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the instruction executor.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked outside reset.
`define LJR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same-cycle implication, checked outside reset.
`define LJR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ljr_pkg.sv @@
// Shared types and constants of the LDA/JSR/RTS executor.
// No dependencies.
`timescale 1ns / 1ps

package ljr_pkg;

  localparam int ADDR_BITS = 16;

  localparam logic [3:0] CMD_STORE  = 4'd0;
  localparam logic [3:0] CMD_LOADPS = 4'd1;
  localparam logic [3:0] CMD_IMM    = 4'd2;
  localparam logic [3:0] CMD_ZP     = 4'd3;
  localparam logic [3:0] CMD_ZPX    = 4'd4;
  localparam logic [3:0] CMD_ABS    = 4'd5;
  localparam logic [3:0] CMD_ABSX   = 4'd6;
  localparam logic [3:0] CMD_ABSY   = 4'd7;
  localparam logic [3:0] CMD_JSR    = 4'd8;
  localparam logic [3:0] CMD_RTS    = 4'd9;

  localparam logic [7:0] STACK_PAGE = 8'h01;
  localparam logic [7:0] SP_RESET   = 8'hFF;

  typedef enum logic [3:0] {
    OP_STORE, OP_LOADPS, OP_IMM, OP_ZP, OP_ZPX,
    OP_ABS, OP_ABSI, OP_JSR, OP_RTS, OP_NOP
  } op_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  accumulator;
    logic        zero_flag;
    logic        negative_flag;
    logic [15:0] program_counter;
    logic [7:0]  stack_pointer;
    logic [2:0]  cycles_used;
  } out_item_t;

  // Decoded transaction held in the queue.
  typedef struct packed {
    op_t         op;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  index;
    logic [2:0]  cycles;
  } q_item_t;

endpackage

@@ hw/rtl/ljr_front.sv @@
// Front end: takes input transactions and decodes the command.
// Depends on ljr_pkg.
`timescale 1ns / 1ps

module ljr_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  ljr_pkg::in_item_t  in_item,
  input  logic               q_full,
  output logic               q_push,
  output ljr_pkg::q_item_t   q_item
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.address = in_item.address;
    q_item.data    = in_item.data;
    q_item.index   = in_item.index_x;
    q_item.op      = ljr_pkg::OP_NOP;
    q_item.cycles  = 3'd0;
    case (in_item.command)
      ljr_pkg::CMD_STORE:  q_item.op = ljr_pkg::OP_STORE;
      ljr_pkg::CMD_LOADPS: q_item.op = ljr_pkg::OP_LOADPS;
      ljr_pkg::CMD_IMM: begin
        q_item.op     = ljr_pkg::OP_IMM;
        q_item.cycles = 3'd1;
      end
      ljr_pkg::CMD_ZP: begin
        q_item.op     = ljr_pkg::OP_ZP;
        q_item.cycles = 3'd2;
      end
      ljr_pkg::CMD_ZPX: begin
        q_item.op     = ljr_pkg::OP_ZPX;
        q_item.cycles = 3'd3;
      end
      ljr_pkg::CMD_ABS: begin
        q_item.op     = ljr_pkg::OP_ABS;
        q_item.cycles = 3'd3;
      end
      ljr_pkg::CMD_ABSX: begin
        q_item.op     = ljr_pkg::OP_ABSI;
        q_item.cycles = 3'd3;
      end
      ljr_pkg::CMD_ABSY: begin
        q_item.op     = ljr_pkg::OP_ABSI;
        q_item.index  = in_item.index_y;
        q_item.cycles = 3'd3;
      end
      ljr_pkg::CMD_JSR: begin
        q_item.op     = ljr_pkg::OP_JSR;
        q_item.cycles = 3'd5;
      end
      ljr_pkg::CMD_RTS: begin
        q_item.op     = ljr_pkg::OP_RTS;
        q_item.cycles = 3'd5;
      end
      default: q_item.op = ljr_pkg::OP_NOP;
    endcase
  end

endmodule

@@ hw/rtl/ljr_queue.sv @@
// Two-entry queue of decoded transactions between front and back end.
// Depends on ljr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ljr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ljr_pkg::q_item_t  push_item,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output ljr_pkg::q_item_t  head_item
);

  ljr_pkg::q_item_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_item  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  `LJR_ASSERT(a_count_range, count_r != 2'd3, "queue count out of range")
  `LJR_ASSERT_IMP(a_pop_nonempty, pop, head_valid, "pop from empty queue")
  `LJR_ASSERT_IMP(a_push_room, push, !full, "push into full queue")

endmodule

@@ hw/rtl/ljr_back.sv @@
// Back end: sequencer that runs decoded transactions against the byte
// memory and the pc/sp/acc/flag registers. Depends on ljr_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ljr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  ljr_pkg::q_item_t   q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output ljr_pkg::out_item_t out_item
);

  localparam int AB = ljr_pkg::ADDR_BITS;
  localparam int MEM_DEPTH = 1 << AB;

  typedef enum logic [2:0] {
    S_IDLE, S_F2, S_F3, S_PUSHL, S_LD, S_POP2, S_POP3, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [7:0]  sp_r, sp_nxt;
  logic [7:0]  acc_r, acc_nxt;
  logic        z_r, z_nxt;
  logic        n_r, n_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic [15:0] tgt_r, tgt_nxt;
  logic        page_r, page_nxt;
  ljr_pkg::q_item_t   item_r, item_nxt;
  ljr_pkg::out_item_t out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [7:0]    mem_r [MEM_DEPTH];
  logic [7:0]    rdata_r;
  logic [AB-1:0] mem_addr;
  logic          mem_we;
  logic [7:0]    mem_wdata;

  logic [15:0] target;
  logic [15:0] eff;
  logic [15:0] ret;
  logic [7:0]  sp_inc;
  logic [15:0] stk_addr;
  logic [15:0] stk_addr_inc;
  logic [7:0]  zpx_addr;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    target       = {rdata_r, lo_r};
    eff          = target + {8'h00, item_r.index};
    ret          = pc_r - 16'd1;
    sp_inc       = sp_r + 8'd1;
    stk_addr     = {ljr_pkg::STACK_PAGE, sp_r};
    stk_addr_inc = {ljr_pkg::STACK_PAGE, sp_inc};
    zpx_addr     = rdata_r + item_r.index;
  end

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    sp_nxt        = sp_r;
    acc_nxt       = acc_r;
    z_nxt         = z_r;
    n_nxt         = n_r;
    lo_nxt        = lo_r;
    tgt_nxt       = tgt_r;
    page_nxt      = page_r;
    item_nxt      = item_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = pc_r[AB-1:0];
    mem_wdata     = item_r.data;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          page_nxt = 1'b0;
          case (q_item.op)
            ljr_pkg::OP_STORE: begin
              mem_we    = 1'b1;
              mem_addr  = q_item.address[AB-1:0];
              mem_wdata = q_item.data;
              state_nxt = S_FIN;
            end
            ljr_pkg::OP_LOADPS: begin
              pc_nxt    = q_item.address;
              sp_nxt    = q_item.data;
              state_nxt = S_FIN;
            end
            ljr_pkg::OP_NOP: state_nxt = S_FIN;
            ljr_pkg::OP_RTS: begin
              sp_nxt    = sp_inc;
              mem_addr  = stk_addr_inc[AB-1:0];
              state_nxt = S_POP2;
            end
            default: begin
              // first operand byte
              pc_nxt    = pc_r + 16'd1;
              state_nxt = S_F2;
            end
          endcase
        end
      end
      S_F2: begin
        lo_nxt = rdata_r;
        case (item_r.op)
          ljr_pkg::OP_IMM: begin
            acc_nxt   = rdata_r;
            z_nxt     = (rdata_r == 8'h00);
            n_nxt     = rdata_r[7];
            state_nxt = S_FIN;
          end
          ljr_pkg::OP_ZP: begin
            mem_addr  = AB'(rdata_r);
            state_nxt = S_LD;
          end
          ljr_pkg::OP_ZPX: begin
            mem_addr  = AB'(zpx_addr);
            state_nxt = S_LD;
          end
          default: begin
            pc_nxt    = pc_r + 16'd1;
            state_nxt = S_F3;
          end
        endcase
      end
      S_F3: begin
        case (item_r.op)
          ljr_pkg::OP_ABS: begin
            mem_addr  = target[AB-1:0];
            state_nxt = S_LD;
          end
          ljr_pkg::OP_ABSI: begin
            mem_addr  = eff[AB-1:0];
            page_nxt  = (eff[15:8] != target[15:8]);
            state_nxt = S_LD;
          end
          ljr_pkg::OP_JSR: begin
            mem_we    = 1'b1;
            mem_addr  = stk_addr[AB-1:0];
            mem_wdata = ret[15:8];
            sp_nxt    = sp_r - 8'd1;
            tgt_nxt   = target;
            state_nxt = S_PUSHL;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_PUSHL: begin
        mem_we    = 1'b1;
        mem_addr  = stk_addr[AB-1:0];
        mem_wdata = ret[7:0];
        sp_nxt    = sp_r - 8'd1;
        pc_nxt    = tgt_r;
        state_nxt = S_FIN;
      end
      S_LD: begin
        acc_nxt   = rdata_r;
        z_nxt     = (rdata_r == 8'h00);
        n_nxt     = rdata_r[7];
        state_nxt = S_FIN;
      end
      S_POP2: begin
        lo_nxt    = rdata_r;
        sp_nxt    = sp_inc;
        mem_addr  = stk_addr_inc[AB-1:0];
        state_nxt = S_POP3;
      end
      S_POP3: begin
        pc_nxt    = target + 16'd1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt         = 1'b1;
          out_nxt.accumulator     = acc_r;
          out_nxt.zero_flag       = z_r;
          out_nxt.negative_flag   = n_r;
          out_nxt.program_counter = pc_r;
          out_nxt.stack_pointer   = sp_r;
          out_nxt.cycles_used     = item_r.cycles + {2'b00, page_r};
          state_nxt             = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= 16'h0000;
      sp_r        <= ljr_pkg::SP_RESET;
      acc_r       <= 8'h00;
      z_r         <= 1'b0;
      n_r         <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      sp_r        <= sp_nxt;
      acc_r       <= acc_nxt;
      z_r         <= z_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    tgt_r  <= tgt_nxt;
    page_r <= page_nxt;
    item_r <= item_nxt;
    out_r  <= out_nxt;
  end

  // single-port byte memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem_r[mem_addr];
  end

  `LJR_ASSERT(a_fin_delivers,
    !(state_r == S_FIN && (!out_valid_r || !out_stall)) || (state_nxt == S_IDLE),
    "finished transaction not moved to output")
  `LJR_ASSERT_IMP(a_write_states, mem_we,
    state_r == S_IDLE || state_r == S_F3 || state_r == S_PUSHL,
    "memory write outside store or push step")
  `LJR_ASSERT_IMP(a_pop_idle, q_pop, state_r == S_IDLE,
    "queue popped while busy")

endmodule

@@ hw/rtl/lda_jsr_rts_executor_top.sv @@
// Top level of the LDA/JSR/RTS executor: front decode, queue, back sequencer.
// Depends on ljr_pkg, ljr_front, ljr_queue, ljr_back.
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   ljr_pkg::in_item_t (command..index_y)
// out_      output     out_valid/out_stall ljr_pkg::out_item_t (accumulator..cycles)
//
// Each transaction is run by the back-end sequencer as a series of states,
// at most one single-port memory access per state plus a final state that
// posts the result. A two-entry queue lets the front take new transactions
// while the back works or the output is stalled.
// Synchronous active-low reset: pc 0, sp 0xFF, acc and flags 0, queue empty.
// Memory contents are not cleared by reset.

module lda_jsr_rts_executor_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ljr_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output ljr_pkg::out_item_t out_item
);

  logic             q_full;
  logic             q_push;
  ljr_pkg::q_item_t q_push_item;
  logic             q_pop;
  logic             q_head_valid;
  ljr_pkg::q_item_t q_head_item;

  // decode command into an operation class and base cycle count
  ljr_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_push_item)
  );

  // decouples acceptance from execution
  ljr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head_item)
  );

  // executes against memory and architectural registers, owns output reg
  ljr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_head_valid),
    .q_item    (q_head_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

@@ tb/lda_jsr_rts_executor_top_tb.sv @@
// Self-checking testbench for lda_jsr_rts_executor_top (LDA modes, JSR, RTS).
// Depends on ljr_pkg and the executor RTL; keeps its own model of the CPU state
// and memory and checks every result transaction against it.
`timescale 1ns / 1ps

module lda_jsr_rts_executor_top_tb;

  // Spare command codes: the block must leave all state alone on these.
  localparam logic [3:0] CMD_SPARE_LO = ljr_pkg::CMD_RTS + 4'd1;
  localparam logic [3:0] CMD_SPARE_HI = 4'hF;

  // Cycle counts reported beyond the opcode fetch.
  localparam logic [2:0] CYC_NONE      = 3'd0;
  localparam logic [2:0] CYC_IMM       = 3'd1;
  localparam logic [2:0] CYC_ZP        = 3'd2;
  localparam logic [2:0] CYC_ZPX       = 3'd3;
  localparam logic [2:0] CYC_ABS       = 3'd3;
  localparam logic [2:0] CYC_ABS_CROSS = 3'd4;
  localparam logic [2:0] CYC_JSR       = 3'd5;
  localparam logic [2:0] CYC_RTS       = 3'd5;

  localparam int unsigned ADDR_SPAN = 1 << ljr_pkg::ADDR_BITS;
  localparam int unsigned ADDR_MASK = ADDR_SPAN - 1;

  localparam int LONG_HOLD      = 400;   // receiver hold-off for the fill test
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transaction at all
  localparam int DRAIN_CYCLES   = 40;    // settle time after the last result
  localparam int MAX_REPORTS    = 10;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  ljr_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  ljr_pkg::out_item_t out_item;

  lda_jsr_rts_executor_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // CPU model. It is advanced once per accepted input transaction, in
  // acceptance order, so at any moment it holds the state the block will
  // have after everything sent so far. The stimulus generator reads it
  // too, to know which memory bytes the next instruction will touch.
  // ---------------------------------------------------------------------
  logic [15:0] cpu_pc  = 16'h0000;
  logic [7:0]  cpu_sp  = ljr_pkg::SP_RESET;
  logic [7:0]  cpu_acc = 8'h00;
  logic        cpu_z   = 1'b0;
  logic        cpu_n   = 1'b0;
  logic [7:0]  mem_image   [0:ADDR_SPAN-1];
  bit          mem_written [0:ADDR_SPAN-1];

  ljr_pkg::out_item_t pending_states[$];   // expected results, oldest first

  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned error_count;
  int unsigned page_cross_count;
  int unsigned cmd_hits [16];

  int unsigned tx_gap_pct;   // chance per transaction of a sender gap
  int unsigned rx_gap_pct;   // chance per cycle of a receiver stall burst
  bit          hold_req;     // asks the receiver for one long hold-off

  function automatic logic [7:0] rd_mem(input logic [31:0] a);
    return mem_image[a & ADDR_MASK];
  endfunction

  function automatic void wr_mem(input logic [31:0] a, input logic [7:0] v);
    mem_image[a & ADDR_MASK]   = v;
    mem_written[a & ADDR_MASK] = 1'b1;
  endfunction

  function automatic logic [7:0] take_operand();
    logic [7:0] v;
    v      = rd_mem(cpu_pc);
    cpu_pc = cpu_pc + 16'd1;
    return v;
  endfunction

  function automatic logic [15:0] take_address();
    logic [7:0] lo;
    logic [7:0] hi;
    lo = take_operand();
    hi = take_operand();
    return {hi, lo};
  endfunction

  function automatic void set_acc(input logic [7:0] v);
    cpu_acc = v;
    cpu_z   = (v == 8'h00);
    cpu_n   = v[7];
  endfunction

  // Stack lives in page one; push writes then decrements, pull is the mirror.
  function automatic void stack_push(input logic [7:0] v);
    wr_mem({ljr_pkg::STACK_PAGE, cpu_sp}, v);
    cpu_sp = cpu_sp - 8'd1;
  endfunction

  function automatic logic [7:0] pull_byte();
    cpu_sp = cpu_sp + 8'd1;
    return rd_mem({ljr_pkg::STACK_PAGE, cpu_sp});
  endfunction

  function automatic ljr_pkg::out_item_t execute_step(input ljr_pkg::in_item_t txn);
    ljr_pkg::out_item_t r;
    logic [15:0] base;
    logic [15:0] eff;
    logic [15:0] ret;
    logic [7:0]  zp;
    logic [7:0]  idx;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [2:0]  cyc;
    cyc = CYC_NONE;
    case (txn.command)
      ljr_pkg::CMD_STORE: wr_mem(txn.address, txn.data);
      ljr_pkg::CMD_LOADPS: begin
        cpu_pc = txn.address;
        cpu_sp = txn.data;
      end
      ljr_pkg::CMD_IMM: begin
        set_acc(take_operand());
        cyc = CYC_IMM;
      end
      ljr_pkg::CMD_ZP: begin
        set_acc(rd_mem(take_operand()));
        cyc = CYC_ZP;
      end
      ljr_pkg::CMD_ZPX: begin
        zp = take_operand() + txn.index_x;   // wraps inside page zero
        set_acc(rd_mem(zp));
        cyc = CYC_ZPX;
      end
      ljr_pkg::CMD_ABS: begin
        set_acc(rd_mem(take_address()));
        cyc = CYC_ABS;
      end
      ljr_pkg::CMD_ABSX, ljr_pkg::CMD_ABSY: begin
        idx  = (txn.command == ljr_pkg::CMD_ABSX) ? txn.index_x : txn.index_y;
        base = take_address();
        eff  = base + idx;                    // wraps at 16 bits
        set_acc(rd_mem(eff));
        if (base[15:8] != eff[15:8]) begin
          cyc = CYC_ABS_CROSS;
          page_cross_count++;
        end else begin
          cyc = CYC_ABS;
        end
      end
      ljr_pkg::CMD_JSR: begin
        base = take_address();
        ret  = cpu_pc - 16'd1;
        stack_push(ret[15:8]);
        stack_push(ret[7:0]);
        cpu_pc = base;
        cyc    = CYC_JSR;
      end
      ljr_pkg::CMD_RTS: begin
        lo     = pull_byte();
        hi     = pull_byte();
        cpu_pc = {hi, lo} + 16'd1;
        cyc    = CYC_RTS;
      end
      default: ;
    endcase
    r.accumulator     = cpu_acc;
    r.zero_flag       = cpu_z;
    r.negative_flag   = cpu_n;
    r.program_counter = cpu_pc;
    r.stack_pointer   = cpu_sp;
    r.cycles_used     = cyc;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Value pickers, biased toward the corners of each field.
  // ---------------------------------------------------------------------
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'h80;
      2:       return 8'hFF;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'hFFFE;
      3:       return 16'h00FF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic ljr_pkg::in_item_t mk_item(input logic [3:0] cmd,
                                                input logic [15:0] a,
                                                input logic [7:0] d, input logic [7:0] x,
                                                input logic [7:0] y);
    ljr_pkg::in_item_t t;
    t.command = cmd;
    t.address = a;
    t.data    = d;
    t.index_x = x;
    t.index_y = y;
    return t;
  endfunction

  // ---------------------------------------------------------------------
  // Input side. valid is raised without looking at stall and the payload
  // is held until the edge that takes it. valid stays high after an
  // acceptance so back-to-back transactions need only one assignment per
  // step; release_input drops it before any pause.
  // ---------------------------------------------------------------------
  task automatic send_cmd(input ljr_pkg::in_item_t txn);
    int unsigned gap;
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= txn;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_states.push_back(execute_step(txn));
    cmd_hits[txn.command]++;
    sent_count++;
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  // Always waits for a clock edge first, so a following send never assigns
  // in_valid in the same step as release_input.
  task automatic wait_drain();
    do @(posedge clk); while (pending_states.size() != 0);
  endtask

  task automatic put_byte(input logic [15:0] a, input logic [7:0] d);
    send_cmd(mk_item(ljr_pkg::CMD_STORE, a, d, 8'($urandom), 8'($urandom)));
  endtask

  // Memory is undefined until written, so every byte an instruction will
  // read gets a store first if it has never been written.
  task automatic ensure_byte(input logic [15:0] a);
    if (!mem_written[a & ADDR_MASK]) put_byte(a, pick_byte());
  endtask

  task automatic run_op(input logic [3:0] cmd, input logic [7:0] x, input logic [7:0] y);
    send_cmd(mk_item(cmd, 16'($urandom), 8'($urandom), x, y));
  endtask

  // Operand bytes at pc: either rewritten with fresh content or just made valid.
  task automatic prep_operands(input int n_ops, input bit fresh);
    int k;
    for (k = 0; k < n_ops; k++) begin
      if (fresh) put_byte(cpu_pc + 16'(k), pick_byte());
      else ensure_byte(cpu_pc + 16'(k));
    end
  endtask

  task automatic issue_lda(input logic [3:0] cmd, input bit fresh);
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  zp;
    logic [15:0] base;
    logic [15:0] eff;
    int          n_ops;
    x = pick_byte();
    y = pick_byte();
    n_ops = (cmd == ljr_pkg::CMD_IMM || cmd == ljr_pkg::CMD_ZP ||
             cmd == ljr_pkg::CMD_ZPX) ? 1 : 2;
    prep_operands(n_ops, fresh);
    base = {rd_mem(cpu_pc + 16'd1), rd_mem(cpu_pc)};
    zp   = base[7:0];
    case (cmd)
      ljr_pkg::CMD_ZP:   eff = {8'h00, zp};
      ljr_pkg::CMD_ZPX:  eff = {8'h00, 8'(zp + x)};
      ljr_pkg::CMD_ABSX: eff = base + x;
      ljr_pkg::CMD_ABSY: eff = base + y;
      default:           eff = base;
    endcase
    if (cmd != ljr_pkg::CMD_IMM) begin
      // never overwrite the operand bytes we just set up
      if (fresh && eff != cpu_pc && eff != cpu_pc + 16'd1) put_byte(eff, pick_byte());
      else ensure_byte(eff);
    end
    run_op(cmd, x, y);
  endtask

  task automatic issue_jsr(input bit fresh);
    prep_operands(2, fresh);
    run_op(ljr_pkg::CMD_JSR, 8'($urandom), 8'($urandom));
  endtask

  task automatic issue_rts();
    ensure_byte({ljr_pkg::STACK_PAGE, 8'(cpu_sp + 8'd1)});
    ensure_byte({ljr_pkg::STACK_PAGE, 8'(cpu_sp + 8'd2)});
    run_op(ljr_pkg::CMD_RTS, 8'($urandom), 8'($urandom));
  endtask

  // One step of random traffic: mostly well-formed instructions with their
  // bytes prepared, plus stray stores, pc/sp reloads and spare commands.
  task automatic random_step();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)
      issue_lda(4'(ljr_pkg::CMD_IMM + $urandom_range(0, 5)), 1'($urandom_range(0, 1)));
    else if (pick < 64) issue_jsr(1'($urandom_range(0, 1)));
    else if (pick < 78) issue_rts();
    else if (pick < 85)
      send_cmd(mk_item(ljr_pkg::CMD_LOADPS, pick_word(), pick_byte(),
                       8'($urandom), 8'($urandom)));
    else if (pick < 95) put_byte(16'($urandom), 8'($urandom));
    else run_op(4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), 8'($urandom), 8'($urandom));
  endtask

  task automatic drive_random(input int unsigned n, input bit vary);
    int unsigned stop_at;
    int unsigned next_repick;
    stop_at     = sent_count + n;
    next_repick = sent_count;
    if (!vary) begin
      tx_gap_pct = 0;
      rx_gap_pct = 0;
    end
    while (sent_count < stop_at) begin
      // idle density changes in stretches, including stretches with none
      if (vary && sent_count >= next_repick) begin
        case ($urandom_range(0, 2))
          0:       tx_gap_pct = 0;
          1:       tx_gap_pct = 10;
          default: tx_gap_pct = 30;
        endcase
        case ($urandom_range(0, 2))
          0:       rx_gap_pct = 0;
          1:       rx_gap_pct = 3;
          default: rx_gap_pct = 10;
        endcase
        next_repick = sent_count + 64;
      end
      random_step();
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Corner cases by hand: reset state, flag values, zero page X wrap, page
  // crossing, 16-bit index wrap, fetch wrap at the top of memory, and stack
  // pointer wrap on both push and pull.
  task automatic test_directed();
    tx_gap_pct = 15;
    rx_gap_pct = 5;
    run_op(CMD_SPARE_HI, 8'hFF, 8'h00);        // reset state, nothing changes
    put_byte(16'h0000, 8'h00);
    run_op(ljr_pkg::CMD_IMM, 8'h00, 8'hFF);    // acc 0, zero flag
    put_byte(16'h0001, 8'hFF);
    put_byte(16'h00FF, 8'h80);
    run_op(ljr_pkg::CMD_ZP, 8'h5A, 8'hA5);     // negative flag
    put_byte(16'h0002, 8'hF0);
    put_byte(16'h000F, 8'h01);
    run_op(ljr_pkg::CMD_ZPX, 8'h1F, 8'h00);    // 0xF0 + 0x1F wraps to 0x0F
    put_byte(16'h0003, 8'hFF);
    put_byte(16'h0004, 8'h00);
    put_byte(16'h0100, 8'h7F);
    run_op(ljr_pkg::CMD_ABSX, 8'h01, 8'h00);   // 0x00FF + 1 crosses a page
    put_byte(16'h0005, 8'hFF);
    put_byte(16'h0006, 8'hFF);
    run_op(ljr_pkg::CMD_ABSY, 8'h00, 8'h02);   // 0xFFFF + 2 wraps to 0x0001
    put_byte(16'h0007, 8'h00);
    put_byte(16'h0008, 8'h01);
    run_op(ljr_pkg::CMD_ABS, 8'h00, 8'h00);
    send_cmd(mk_item(ljr_pkg::CMD_LOADPS, 16'hFFFF, 8'h00, 8'h00, 8'hFF));
    put_byte(16'hFFFF, 8'h10);
    run_op(ljr_pkg::CMD_JSR, 8'h00, 8'h00);    // operand fetch wraps, sp 0 -> 0xFE
    run_op(ljr_pkg::CMD_RTS, 8'h00, 8'h00);    // pulls wrap sp back to 0
    put_byte(16'hFFFF, 8'hFF);
  endtask

  task automatic test_random_traffic(input int unsigned n);
    drive_random(n, 1'b1);
  endtask

  // Receiver holds off for a long stretch while we keep offering; the
  // internal queue fills and in_stall must rise and later fall.
  task automatic test_output_hold();
    tx_gap_pct = 0;
    rx_gap_pct = 0;
    hold_req   = 1'b1;
    repeat (24) random_step();
  endtask

  // Sender goes quiet until the block has handed back every result.
  task automatic test_idle_drain();
    release_input();
    wait_drain();
    repeat (8) random_step();
  endtask

  // Final stretch with no idling on either side.
  task automatic test_steady_stream(input int unsigned n);
    drive_random(n, 1'b0);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stall bursts, or one long hold-off on request.
  // ---------------------------------------------------------------------
  initial begin : receiver
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (rx_gap_pct != 0 && $urandom_range(0, 99) < rx_gap_pct) begin
        n = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation.
  // ---------------------------------------------------------------------
  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  always @(posedge clk) begin : result_checker
    ljr_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      checked_count++;
      if (pending_states.size() == 0) begin
        flag_error($sformatf({"ERROR unexpected result: acc=%02h z=%b n=%b pc=%04h ",
                              "sp=%02h cyc=%0d"},
                             out_item.accumulator, out_item.zero_flag, out_item.negative_flag,
                             out_item.program_counter, out_item.stack_pointer,
                             out_item.cycles_used));
      end else begin
        want = pending_states.pop_front();
        if (out_item.accumulator     !== want.accumulator     ||
            out_item.zero_flag       !== want.zero_flag       ||
            out_item.negative_flag   !== want.negative_flag   ||
            out_item.program_counter !== want.program_counter ||
            out_item.stack_pointer   !== want.stack_pointer   ||
            out_item.cycles_used     !== want.cycles_used) begin
          flag_error($sformatf({"ERROR result %0d: exp acc=%02h z=%b n=%b pc=%04h sp=%02h ",
                                "cyc=%0d, got acc=%02h z=%b n=%b pc=%04h sp=%02h cyc=%0d"},
                               checked_count, want.accumulator, want.zero_flag,
                               want.negative_flag, want.program_counter, want.stack_pointer,
                               want.cycles_used, out_item.accumulator, out_item.zero_flag,
                               out_item.negative_flag, out_item.program_counter,
                               out_item.stack_pointer, out_item.cycles_used));
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either channel.
  int unsigned quiet_cycles;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_states.size());
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int unsigned lda_total;
    int c;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    hold_req = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_traffic(800);
    test_output_hold();
    test_idle_drain();
    test_random_traffic(700);
    test_steady_stream(250);

    release_input();
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    lda_total = 0;
    for (c = ljr_pkg::CMD_IMM; c <= ljr_pkg::CMD_ABSY; c++) lda_total += cmd_hits[c];
    $display({"summary: %0d transactions in (%0d stores, %0d pc/sp loads, ",
              "%0d LDA, %0d JSR, %0d RTS)"},
             sent_count, cmd_hits[ljr_pkg::CMD_STORE], cmd_hits[ljr_pkg::CMD_LOADPS],
             lda_total, cmd_hits[ljr_pkg::CMD_JSR], cmd_hits[ljr_pkg::CMD_RTS]);
    $display("summary: %0d results checked, %0d page-crossing indexed loads, %0d errors",
             checked_count, page_cross_count, error_count);
    if (error_count == 0 && pending_states.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/ljr_pkg.sv
hw/rtl/ljr_front.sv
hw/rtl/ljr_queue.sv
hw/rtl/ljr_back.sv
hw/rtl/lda_jsr_rts_executor_top.sv
tb/lda_jsr_rts_executor_top_tb.sv
